@@ src/dbcs_pkg.sv @@
// shared types and constants of the double-byte code page decoder
package dbcs_pkg;

   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 16;
   localparam int ENTRY_W  = 3 * CODE_W;
   localparam int INDEX_W  = CODE_W + 1;
   localparam int COUNT_W  = 7;
   localparam int LEAD_DEPTH = 256;

   localparam logic [CODE_W-1:0] NO_MAPPING = 16'hFFFF;

   // register index of range_count on the csr port
   localparam logic REG_RANGE_COUNT = 1'b0;

   typedef enum logic [1:0] {
      CMD_LOAD_LEAD  = 2'd0,
      CMD_LOAD_RANGE = 2'd1,
      CMD_LOAD_TABLE = 2'd2,
      CMD_CONVERT    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEAD,
      ST_SCAN,
      ST_TABLE
   } state_type;

   typedef struct packed {
      logic               hit;
      logic               in_bounds;
      logic [INDEX_W-1:0] index;
   } range_hit_type;

endpackage

@@ src/dbcs_to_utf16_decoder_core.sv @@
// top level: command decode, lookup sequencer, stores and csr port
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   request  | start, busy            | req_command .. req_end_of_string
//   response | rsp_valid (one cycle)  | rsp_code_unit, rsp_last_unit
//   csr      | psel, penable, pwrite  | paddr, pwdata, prdata (range_count)
//
// loads never raise busy. a convert keeps busy high through one lead flag read,
// a descriptor scan of at most n = min(range_count, MAX_RANGES) entries at one
// entry per cycle through the range memory read port, and one code table read;
// a held lead byte ends after the lead flag read with no result. the result
// shows in the same cycle that busy drops. synchronous reset clears control state and
// range_count; the stores hold garbage until loaded. results cannot be stalled.
module dbcs_to_utf16_decoder_core #(
   parameter int MAX_RANGES  = 64,
   parameter int TABLE_DEPTH = 16384
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_load_address,
   input  logic        req_lead_flag,
   input  logic [15:0] req_range_low,
   input  logic [15:0] req_range_high,
   input  logic [15:0] req_range_base,
   input  logic [15:0] req_table_word,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_string,
   // response channel
   output logic        rsp_valid,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_unit,
   // csr port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int RCW = $clog2(MAX_RANGES + 1);
   localparam int CW  = (RCW > dbcs_pkg::COUNT_W) ? RCW : dbcs_pkg::COUNT_W;

   dbcs_pkg::state_type   state_ff, state_in;
   dbcs_pkg::command_type cmd;

   logic [dbcs_pkg::COUNT_W-1:0] range_count_ff;
   logic [CW-1:0]                limit;
   logic [CW-1:0]                issue_ff, issue_in;
   logic                         check_ff, check_in;
   logic                         pending_ff, pending_in;
   logic [dbcs_pkg::BYTE_W-1:0]  held_ff, held_in;
   logic [dbcs_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                         last_ff, last_in;
   logic [dbcs_pkg::CODE_W-1:0]  code_ff, code_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dbcs_pkg::CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic accept;
   logic go_scan;
   logic csr_write;

   logic                          lead_wr_en;
   logic                          lead_rd_data;
   logic                          range_wr_en;
   logic [dbcs_pkg::ENTRY_W-1:0]  range_rd_data;
   logic                          table_wr_en;
   logic [TAW-1:0]                table_rd_addr;
   logic [dbcs_pkg::CODE_W-1:0]   table_rd_data;
   dbcs_pkg::range_hit_type       hit;

   assign cmd    = dbcs_pkg::command_type'(req_command);
   assign busy   = (state_ff != dbcs_pkg::ST_IDLE);
   assign accept = start && !busy;

   // loads are written at the accept edge, out-of-range slots dropped
   assign lead_wr_en  = accept && (cmd == dbcs_pkg::CMD_LOAD_LEAD)
                        && (req_load_address[15:8] == 8'd0);
   assign range_wr_en = accept && (cmd == dbcs_pkg::CMD_LOAD_RANGE)
                        && ({1'b0, req_load_address} < 17'(MAX_RANGES));
   assign table_wr_en = accept && (cmd == dbcs_pkg::CMD_LOAD_TABLE)
                        && ({1'b0, req_load_address} < 17'(TABLE_DEPTH));

   assign limit = (CW'(range_count_ff) > CW'(MAX_RANGES))
                  ? CW'(MAX_RANGES)
                  : CW'(range_count_ff);

   // a lead byte mid-string is only held; everything else gets looked up
   assign go_scan = pending_ff || !lead_rd_data || last_ff;

   assign table_rd_addr = hit.index[TAW-1:0];

   dbcs_ram #(
      .WIDTH (1),
      .DEPTH (dbcs_pkg::LEAD_DEPTH)
   ) u_lead_ram (
      .clock   (clock),
      .wr_en   (lead_wr_en),
      .wr_addr (req_load_address[7:0]),
      .wr_data (req_lead_flag),
      .rd_addr (req_text_byte),
      .rd_data (lead_rd_data)
   );

   dbcs_ram #(
      .WIDTH (dbcs_pkg::ENTRY_W),
      .DEPTH (MAX_RANGES)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (range_wr_en),
      .wr_addr (req_load_address[RAW-1:0]),
      .wr_data ({req_range_low, req_range_high, req_range_base}),
      .rd_addr (issue_ff[RAW-1:0]),
      .rd_data (range_rd_data)
   );

   dbcs_ram #(
      .WIDTH (dbcs_pkg::CODE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .wr_addr (req_load_address[TAW-1:0]),
      .wr_data (req_table_word),
      .rd_addr (table_rd_addr),
      .rd_data (table_rd_data)
   );

   dbcs_range_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_range_unit (
      .code   (code_ff),
      .entry  (range_rd_data),
      .result (hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dbcs_pkg::ST_IDLE: begin
            if (accept && (cmd == dbcs_pkg::CMD_CONVERT)) begin
               state_in = dbcs_pkg::ST_LEAD;
            end
         end
         dbcs_pkg::ST_LEAD: begin
            if (go_scan && (limit != '0)) begin
               state_in = dbcs_pkg::ST_SCAN;
            end else begin
               state_in = dbcs_pkg::ST_IDLE;
            end
         end
         dbcs_pkg::ST_SCAN: begin
            if (check_ff && hit.hit && hit.in_bounds) begin
               state_in = dbcs_pkg::ST_TABLE;
            end else if (check_ff && (hit.hit || (issue_ff == limit))) begin
               state_in = dbcs_pkg::ST_IDLE;
            end
         end
         dbcs_pkg::ST_TABLE: begin
            state_in = dbcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = dbcs_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      issue_in     = issue_ff;
      check_in     = check_ff;
      pending_in   = pending_ff;
      held_in      = held_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      code_in      = code_ff;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         dbcs_pkg::ST_IDLE: begin
            if (accept && (cmd == dbcs_pkg::CMD_CONVERT)) begin
               byte_in = req_text_byte;
               last_in = req_end_of_string;
            end
         end
         dbcs_pkg::ST_LEAD: begin
            issue_in = '0;
            check_in = 1'b0;
            if (pending_ff) begin
               code_in    = {held_ff, byte_ff};
               pending_in = 1'b0;
               held_in    = '0;
            end else if (lead_rd_data) begin
               // a lead at end of string pairs with a zero trail
               code_in = {byte_ff, 8'd0};
               if (!last_ff) begin
                  held_in    = byte_ff;
                  pending_in = 1'b1;
               end
            end else begin
               code_in = {8'd0, byte_ff};
            end
            if (go_scan && (limit == '0)) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = dbcs_pkg::NO_MAPPING;
               rsp_last_in  = last_ff;
            end
         end
         dbcs_pkg::ST_SCAN: begin
            // read of entry issue_ff goes out while entry issue_ff - 1 is checked
            if (issue_ff < limit) begin
               issue_in = issue_ff + 1'b1;
               check_in = 1'b1;
            end else begin
               check_in = 1'b0;
            end
            if (check_ff && ((hit.hit && !hit.in_bounds)
                             || (!hit.hit && (issue_ff == limit)))) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = dbcs_pkg::NO_MAPPING;
               rsp_last_in  = last_ff;
            end
         end
         dbcs_pkg::ST_TABLE: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = table_rd_data;
            rsp_last_in  = last_ff;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign csr_write = psel && penable && pwrite && (paddr[2] == dbcs_pkg::REG_RANGE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dbcs_pkg::ST_IDLE;
         pending_ff     <= 1'b0;
         held_ff        <= '0;
         check_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         range_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         held_ff      <= held_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            range_count_ff <= pwdata[dbcs_pkg::COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      code_ff     <= code_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_unit = rsp_code_ff;
   assign rsp_last_unit = rsp_last_ff;

   assign prdata = {{(32 - dbcs_pkg::COUNT_W){1'b0}}, range_count_ff};
   assign pready = 1'b1;

endmodule

@@ src/dbcs_ram.sv @@
// generic single-write, single-read ram with registered read data
module dbcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/dbcs_range_unit.sv @@
// shared range compare and table index unit, one descriptor per use
module dbcs_range_unit #(
   parameter int TABLE_DEPTH = 16384
) (
   input  logic [dbcs_pkg::CODE_W-1:0]  code,
   input  logic [dbcs_pkg::ENTRY_W-1:0] entry,
   output dbcs_pkg::range_hit_type      result
);

   logic [dbcs_pkg::CODE_W-1:0] lo;
   logic [dbcs_pkg::CODE_W-1:0] hi;
   logic [dbcs_pkg::CODE_W-1:0] base;
   logic [dbcs_pkg::CODE_W-1:0] offset;

   assign lo     = entry[3*dbcs_pkg::CODE_W-1:2*dbcs_pkg::CODE_W];
   assign hi     = entry[2*dbcs_pkg::CODE_W-1:dbcs_pkg::CODE_W];
   assign base   = entry[dbcs_pkg::CODE_W-1:0];
   assign offset = code - lo;

   always_comb begin
      result.hit       = (code >= lo) && (code <= hi);
      result.index     = {1'b0, base} + {1'b0, offset};
      result.in_bounds = result.index < dbcs_pkg::INDEX_W'(TABLE_DEPTH);
   end

endmodule
